/* rtl/unicode_text_decoder_macros.svh */
// Assertion macros for the unicode text decoder.
`ifndef UNICODE_TEXT_DECODER_MACROS_SVH
`define UNICODE_TEXT_DECODER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define UTD_ASSERT_HOLDS(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define UTD_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/utd_pkg.sv */
// Types and constants for the unicode text decoder.
package utd_pkg;

  typedef enum logic [2:0] {
    ENC_UTF8    = 3'd0,
    ENC_UTF16LE = 3'd1,
    ENC_UTF16BE = 3'd2,
    ENC_UTF32LE = 3'd3,
    ENC_UTF32BE = 3'd4
  } enc_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_TRUNC   = 2'd2,
    ST_SHORT   = 2'd3
  } status_t;

  typedef struct packed {
    logic [31:0] code_point;
    status_t     status;
    enc_t        encoding;
    logic        last_result;
  } result_t;

  // Byte order mark bytes
  localparam logic [7:0] BOM_00 = 8'h00;
  localparam logic [7:0] BOM_EF = 8'hef;
  localparam logic [7:0] BOM_BB = 8'hbb;
  localparam logic [7:0] BOM_BF = 8'hbf;
  localparam logic [7:0] BOM_FE = 8'hfe;
  localparam logic [7:0] BOM_FF = 8'hff;

  // UTF-16 surrogate tags (top six bits of a unit)
  localparam logic [5:0] HI_SURR_TAG = 6'b110110;
  localparam logic [5:0] LO_SURR_TAG = 6'b110111;
  localparam logic [31:0] SUPP_BASE  = 32'h0001_0000;

  // UTF-8 continuation tag (top two bits)
  localparam logic [1:0] CONT_TAG = 2'b10;

endpackage

/* rtl/unicode_text_decoder.sv */
// Unicode text decoder: byte stream in, code points with status out.
//
//   Input channel (byte_valid / byte_stall) carries one raw byte per item plus
//   last_byte, which marks the final byte of a stream. Output channel
//   (result_valid / result_stall) carries one decoded character per item:
//   code_point, status (ok, invalid, truncated, too short), encoding and
//   last_result on the final result of a stream.
//   The first four bytes are held to look for a byte order mark (UTF-32 LE/BE,
//   UTF-8, UTF-16 LE/BE; plain UTF-8 when none). After the fourth byte the held
//   bytes past the mark are replayed, one per cycle, so the input stalls there
//   (not after a UTF-32 mark). Otherwise one byte a cycle. Both rates hold only
//   while the result buffer has room. A result is offered the cycle after the
//   byte or replay step that completes it, behind older results still in the
//   buffer. A cycle adds at most two results; the byte that completes the head
//   can give four over its replay. byte_stall rises during the replay and when
//   the result buffer has fewer than three free entries, so a stalled receiver
//   backs up the input; nothing drops. Reset (synchronous, rst high) empties
//   the buffer; it and every last byte return the decoder to a stream's start.
`include "unicode_text_decoder_macros.svh"

module unicode_text_decoder #(
  parameter int FIFO_DEPTH = 8  // result buffer entries, power of two, >= 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [31:0] code_point,
  output logic [1:0]  status,
  output logic [2:0]  encoding,
  output logic        last_result
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  // Stream state
  logic [7:0]          head_bytes [4];
  logic [2:0]          head_count,       head_count_next;
  logic                mode_known,       mode_known_next;
  utd_pkg::enc_t       encoding_mode,    encoding_mode_next;
  logic [31:0]         code_accumulator, code_accumulator_next;
  logic [2:0]          bytes_remaining,  bytes_remaining_next;
  logic [1:0]          unit_byte_count,  unit_byte_count_next;
  logic [9:0]          pending_high,     pending_high_next;
  logic                high_valid,       high_valid_next;

  // Mark replay of held bytes
  logic                replaying,        replaying_next;
  logic [1:0]          replay_idx,       replay_idx_next;
  logic                replay_last,      replay_last_next;

  // Result buffer
  utd_pkg::result_t    fifo_q [FIFO_DEPTH];
  logic [PTR_W-1:0]    wr_ptr;
  logic [PTR_W-1:0]    rd_ptr;
  logic [CNT_W-1:0]    fifo_count;
  logic [PTR_W-1:0]    wr_addr [3];

  // Step results
  utd_pkg::result_t    res [3];
  logic [1:0]          nres;
  logic                space;
  logic                in_go;
  logic                head_we;
  logic                pop;
  logic                stream_end;

  assign space        = fifo_count <= CNT_W'(FIFO_DEPTH - 3);
  assign byte_stall   = replaying || !space;
  assign in_go        = byte_valid && !byte_stall;
  assign head_we      = in_go && !mode_known;
  assign result_valid = fifo_count != '0;
  assign pop          = result_valid && !result_stall;

  assign code_point   = fifo_q[rd_ptr].code_point;
  assign status       = fifo_q[rd_ptr].status;
  assign encoding     = fifo_q[rd_ptr].encoding;
  assign last_result  = fifo_q[rd_ptr].last_result;

  always_comb begin
    logic [7:0]  b;
    logic [15:0] u;
    logic        feed_en;
    logic        fin_last;
    logic        lead;
    logic [2:0]  mark_len;
    utd_pkg::enc_t det;

    head_count_next       = head_count;
    mode_known_next       = mode_known;
    encoding_mode_next    = encoding_mode;
    code_accumulator_next = code_accumulator;
    bytes_remaining_next  = bytes_remaining;
    unit_byte_count_next  = unit_byte_count;
    pending_high_next     = pending_high;
    high_valid_next       = high_valid;
    replaying_next        = replaying;
    replay_idx_next       = replay_idx;
    replay_last_next      = replay_last;
    stream_end            = 1'b0;
    nres                  = 2'd0;
    res[0]                = '0;
    res[1]                = '0;
    res[2]                = '0;
    feed_en               = 1'b0;
    fin_last              = 1'b0;
    lead                  = 1'b0;
    u                     = '0;
    det                   = utd_pkg::ENC_UTF8;
    mark_len              = 3'd0;
    b                     = replaying ? head_bytes[replay_idx] : data_byte;

    if (replaying) begin
      if (space) begin
        feed_en  = 1'b1;
        fin_last = replay_last && (replay_idx == 2'd3);
        if (replay_idx == 2'd3) begin
          replaying_next = 1'b0;
        end else begin
          replay_idx_next = replay_idx + 2'd1;
        end
      end
    end else if (in_go) begin
      if (!mode_known) begin
        if (head_count != 3'd3) begin
          if (last_byte) begin
            res[0]     = '{code_point: '0, status: utd_pkg::ST_SHORT,
                           encoding: utd_pkg::ENC_UTF8, last_result: 1'b1};
            nres       = 2'd1;
            stream_end = 1'b1;
          end else begin
            head_count_next = head_count + 3'd1;
          end
        end else begin
          // Fourth byte: pick the mark, first match wins
          if (head_bytes[0] == utd_pkg::BOM_FF && head_bytes[1] == utd_pkg::BOM_FE &&
              head_bytes[2] == utd_pkg::BOM_00 && data_byte == utd_pkg::BOM_00) begin
            det = utd_pkg::ENC_UTF32LE;  mark_len = 3'd4;
          end else if (head_bytes[0] == utd_pkg::BOM_00 &&
                       head_bytes[1] == utd_pkg::BOM_00 &&
                       head_bytes[2] == utd_pkg::BOM_FE && data_byte == utd_pkg::BOM_FF) begin
            det = utd_pkg::ENC_UTF32BE;  mark_len = 3'd4;
          end else if (head_bytes[0] == utd_pkg::BOM_EF &&
                       head_bytes[1] == utd_pkg::BOM_BB &&
                       head_bytes[2] == utd_pkg::BOM_BF) begin
            det = utd_pkg::ENC_UTF8;     mark_len = 3'd3;
          end else if (head_bytes[0] == utd_pkg::BOM_FF &&
                       head_bytes[1] == utd_pkg::BOM_FE) begin
            det = utd_pkg::ENC_UTF16LE;  mark_len = 3'd2;
          end else if (head_bytes[0] == utd_pkg::BOM_FE &&
                       head_bytes[1] == utd_pkg::BOM_FF) begin
            det = utd_pkg::ENC_UTF16BE;  mark_len = 3'd2;
          end
          encoding_mode_next = det;
          head_count_next    = 3'd4;
          mode_known_next    = 1'b1;
          if (mark_len == 3'd4) begin
            // Whole head is the mark: nothing to replay
            stream_end = last_byte;
          end else begin
            replaying_next   = 1'b1;
            replay_idx_next  = mark_len[1:0];
            replay_last_next = last_byte;
          end
        end
      end else begin
        feed_en  = 1'b1;
        fin_last = last_byte;
      end
    end

    if (feed_en) begin
      case (encoding_mode)
        utd_pkg::ENC_UTF16LE, utd_pkg::ENC_UTF16BE: begin
          if (unit_byte_count == 2'd0) begin
            code_accumulator_next = {24'd0, b};
            unit_byte_count_next  = 2'd1;
          end else begin
            u = (encoding_mode == utd_pkg::ENC_UTF16BE) ?
                {code_accumulator[7:0], b} : {b, code_accumulator[7:0]};
            unit_byte_count_next  = 2'd0;
            code_accumulator_next = '0;
            lead = 1'b1;
            if (high_valid) begin
              high_valid_next   = 1'b0;
              pending_high_next = '0;
              if (u[15:10] == utd_pkg::LO_SURR_TAG) begin
                res[nres] = '{code_point: utd_pkg::SUPP_BASE +
                                          {12'd0, pending_high, u[9:0]},
                              status: utd_pkg::ST_OK, encoding: encoding_mode,
                              last_result: 1'b0};
                nres = nres + 2'd1;
                lead = 1'b0;
              end else begin
                // Broken pair: flag it, then treat unit as a first unit
                res[nres] = '{code_point: '0, status: utd_pkg::ST_INVALID,
                              encoding: encoding_mode, last_result: 1'b0};
                nres = nres + 2'd1;
              end
            end
            if (lead) begin
              if (u[15:10] == utd_pkg::HI_SURR_TAG) begin
                pending_high_next = u[9:0];
                high_valid_next   = 1'b1;
              end else begin
                res[nres] = '{code_point: {16'd0, u}, status: utd_pkg::ST_OK,
                              encoding: encoding_mode, last_result: 1'b0};
                nres = nres + 2'd1;
              end
            end
          end
        end
        utd_pkg::ENC_UTF32LE, utd_pkg::ENC_UTF32BE: begin
          if (encoding_mode == utd_pkg::ENC_UTF32BE) begin
            code_accumulator_next = {code_accumulator[23:0], b};
          end else begin
            code_accumulator_next = code_accumulator |
                                    ({24'd0, b} << {unit_byte_count, 3'b000});
          end
          if (unit_byte_count == 2'd3) begin
            res[nres] = '{code_point: code_accumulator_next, status: utd_pkg::ST_OK,
                          encoding: encoding_mode, last_result: 1'b0};
            nres = nres + 2'd1;
            code_accumulator_next = '0;
            unit_byte_count_next  = 2'd0;
          end else begin
            unit_byte_count_next = unit_byte_count + 2'd1;
          end
        end
        default: begin
          lead = 1'b1;
          if (bytes_remaining != 3'd0) begin
            if (b[7:6] == utd_pkg::CONT_TAG) begin
              lead                  = 1'b0;
              code_accumulator_next = {code_accumulator[25:0], b[5:0]};
              bytes_remaining_next  = bytes_remaining - 3'd1;
              if (bytes_remaining == 3'd1) begin
                res[nres] = '{code_point: code_accumulator_next,
                              status: utd_pkg::ST_OK, encoding: encoding_mode,
                              last_result: 1'b0};
                nres = nres + 2'd1;
                code_accumulator_next = '0;
              end
            end else begin
              // Bad continuation: flag, then reuse byte as a lead
              res[nres] = '{code_point: '0, status: utd_pkg::ST_INVALID,
                            encoding: encoding_mode, last_result: 1'b0};
              nres = nres + 2'd1;
              bytes_remaining_next  = 3'd0;
              code_accumulator_next = '0;
            end
          end
          if (lead) begin
            if (b[7] == 1'b0) begin
              res[nres] = '{code_point: {24'd0, b}, status: utd_pkg::ST_OK,
                            encoding: encoding_mode, last_result: 1'b0};
              nres = nres + 2'd1;
            end else if (b[7:5] == 3'b110) begin
              code_accumulator_next = {27'd0, b[4:0]};
              bytes_remaining_next  = 3'd1;
            end else if (b[7:4] == 4'b1110) begin
              code_accumulator_next = {28'd0, b[3:0]};
              bytes_remaining_next  = 3'd2;
            end else if (b[7:3] == 5'b11110) begin
              code_accumulator_next = {29'd0, b[2:0]};
              bytes_remaining_next  = 3'd3;
            end else if (b[7:2] == 6'b111110) begin
              code_accumulator_next = {30'd0, b[1:0]};
              bytes_remaining_next  = 3'd4;
            end else if (b[7:1] == 7'b1111110) begin
              code_accumulator_next = {31'd0, b[0]};
              bytes_remaining_next  = 3'd5;
            end else begin
              // Stray continuation, FE or FF
              res[nres] = '{code_point: '0, status: utd_pkg::ST_INVALID,
                            encoding: encoding_mode, last_result: 1'b0};
              nres = nres + 2'd1;
            end
          end
        end
      endcase

      if (fin_last) begin
        if (bytes_remaining_next != 3'd0 || unit_byte_count_next != 2'd0 ||
            high_valid_next) begin
          res[nres] = '{code_point: '0, status: utd_pkg::ST_TRUNC,
                        encoding: encoding_mode, last_result: 1'b0};
          nres = nres + 2'd1;
        end
        if (nres != 2'd0) begin
          res[nres - 2'd1].last_result = 1'b1;
        end
        stream_end = 1'b1;
      end
    end

    if (stream_end) begin
      head_count_next       = 3'd0;
      mode_known_next       = 1'b0;
      encoding_mode_next    = utd_pkg::ENC_UTF8;
      code_accumulator_next = '0;
      bytes_remaining_next  = 3'd0;
      unit_byte_count_next  = 2'd0;
      pending_high_next     = '0;
      high_valid_next       = 1'b0;
      replaying_next        = 1'b0;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      wr_addr[k] = wr_ptr + PTR_W'(k);
    end
  end

  // Held head bytes
  always_ff @(posedge clk) begin
    if (head_we) begin
      head_bytes[head_count[1:0]] <= data_byte;
    end
  end

  // Result buffer storage
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (2'(k) < nres) begin
        fifo_q[wr_addr[k]] <= res[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_count       <= 3'd0;
      mode_known       <= 1'b0;
      encoding_mode    <= utd_pkg::ENC_UTF8;
      code_accumulator <= '0;
      bytes_remaining  <= 3'd0;
      unit_byte_count  <= 2'd0;
      pending_high     <= '0;
      high_valid       <= 1'b0;
      replaying        <= 1'b0;
      replay_idx       <= 2'd0;
      replay_last      <= 1'b0;
      wr_ptr           <= '0;
      rd_ptr           <= '0;
      fifo_count       <= '0;
    end else begin
      head_count       <= head_count_next;
      mode_known       <= mode_known_next;
      encoding_mode    <= encoding_mode_next;
      code_accumulator <= code_accumulator_next;
      bytes_remaining  <= bytes_remaining_next;
      unit_byte_count  <= unit_byte_count_next;
      pending_high     <= pending_high_next;
      high_valid       <= high_valid_next;
      replaying        <= replaying_next;
      replay_idx       <= replay_idx_next;
      replay_last      <= replay_last_next;
      wr_ptr           <= wr_ptr + PTR_W'(nres);
      rd_ptr           <= rd_ptr + PTR_W'(pop);
      fifo_count       <= fifo_count + CNT_W'(nres) - CNT_W'(pop);
    end
  end

  // Checks
  `UTD_ASSERT_HOLDS(a_fifo_bound, clk, rst, 1'b1, fifo_count <= CNT_W'(FIFO_DEPTH), "result buffer overflow")
  `UTD_ASSERT_HOLDS(a_replay_known, clk, rst, replaying, mode_known, "replay without a decided mark")
  `UTD_ASSERT_NEXT(a_stream_clear, clk, rst, stream_end, !mode_known && head_count == 3'd0 && bytes_remaining == 3'd0 && unit_byte_count == 2'd0 && !high_valid, "state not cleared after stream end")
  `UTD_ASSERT_HOLDS(a_err_zero, clk, rst, result_valid && status != utd_pkg::ST_OK, code_point == 32'd0, "error result with nonzero code point")

endmodule
